// ===== design/oaht_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the open-addressing hash table.
// No dependencies; every other file imports this package.
package oaht_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 10;
  localparam int SOUT_W  = 11;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 64;
  localparam int PCT_W   = 7;

  localparam int HASH_SHR = 33;
  localparam int HASH_SHL = 11;
  localparam int PCT_SCALE = 100;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd77;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PUT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_ITER_END  = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_DEFAULT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_THRESH  = 2'd1;

  // flag encoding: bit 0 occupied, bit 1 tombstone
  localparam logic [1:0] FL_EMPTY = 2'b00;
  localparam logic [1:0] FL_LIVE  = 2'b01;
  localparam logic [1:0] FL_TOMB  = 2'b11;

  typedef struct packed {
    logic       flag_we;
    logic       key_we;
    logic       val_we;
    logic [1:0] flags;
  } store_wr_t;

  function automatic logic [KEY_W-1:0] key_mix(input logic [KEY_W-1:0] k);
    return (k >> HASH_SHR) ^ k ^ (k << HASH_SHL);
  endfunction

endpackage

// ===== design/oaht_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the hash table.
// Depends on oaht_pkg for field widths.
interface oaht_req_if;
  import oaht_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, action, key, value, slot, input ready);
  modport sink   (input valid, action, key, value, slot, output ready);
endinterface

interface oaht_rsp_if;
  import oaht_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              existed;
  logic [SOUT_W-1:0] slot_out;
  logic [VAL_W-1:0]  value_out;
  logic [SOUT_W-1:0] entry_count;
  logic              over_threshold;
  modport source (output valid, status, existed, slot_out, value_out, entry_count,
                  over_threshold, input ready);
  modport sink   (input valid, status, existed, slot_out, value_out, entry_count,
                  over_threshold, output ready);
endinterface

// ===== design/oaht_store.sv =====
`timescale 1ns / 1ps
// Slot storage: flag, key and value memories on one shared address.
// Depends on oaht_pkg for the write-control struct.
module oaht_store #(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic                    clk,
  input  logic [IW-1:0]           addr,
  input  oaht_pkg::store_wr_t     wr,
  input  logic [63:0]             wkey,
  input  logic [63:0]             wval,
  output logic [1:0]              rflags,
  output logic [63:0]             rkey,
  output logic [63:0]             rval
);
  import oaht_pkg::*;

  logic [1:0]       flag_mem [DEPTH];
  logic [KEY_W-1:0] key_mem  [DEPTH];
  logic [VAL_W-1:0] val_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.flag_we) flag_mem[addr] <= wr.flags;
    rflags <= flag_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.key_we) key_mem[addr] <= wkey;
    rkey <= key_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_we) val_mem[addr] <= wval;
    rval <= val_mem[addr];
  end

endmodule

// ===== design/open_addressing_hash_table.sv =====
`timescale 1ns / 1ps
// Open-addressing hash table top level: sequencer, probe unit, bounds and output register.
// Depends on oaht_pkg, oaht_if and oaht_store.
//
//   channel  | dir | handshake        | beat
//   ---------+-----+------------------+-------------------------------------------
//   req      | in  | valid/ready      | action, key, value, slot
//   rsp      | out | valid/ready      | status, existed, slot_out, value_out, ...
//   cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// Steps: each probed or scanned slot takes an address step and an evaluate step on the
// single slot-memory port. A remove rescans the bounds when the removed slot was the first
// or last used one; a refused remove or an undefined action touches no slot; next scans
// upward for a live slot; the reset action runs the clearing pass again.
// Reset: after rst a clearing pass over every slot wipes the flags; no beat is taken then.
// Stalls: a finished result waits for the output register; the sequencer holds in its done
// state until the register frees, and req is ready only while the sequencer is idle.
module open_addressing_hash_table #(
  parameter int BUCKETS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [oaht_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [oaht_pkg::CFG_DW-1:0]   cfg_data,
  oaht_req_if.sink                      req,
  oaht_rsp_if.source                    rsp
);
  import oaht_pkg::*;

  localparam int IW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int JW = (CW > SOUT_W) ? CW : SOUT_W;
  localparam int PW = CW + PCT_W;
  localparam logic [SOUT_W-1:0] NO_SLOT = SOUT_W'(BUCKETS);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_PRB_ADDR = 13'b0000000000100,
    S_PRB_EVAL = 13'b0000000001000,
    S_INS_WR   = 13'b0000000010000,
    S_REM_ADDR = 13'b0000000100000,
    S_REM_EVAL = 13'b0000001000000,
    S_UP_ADDR  = 13'b0000010000000,
    S_UP_EVAL  = 13'b0000100000000,
    S_DN_ADDR  = 13'b0001000000000,
    S_DN_EVAL  = 13'b0010000000000,
    S_NXT_ADDR = 13'b0100000000000,
    S_NXT_EVAL = 13'b1000000000000
  } state_t;

  // done: a finished result waits here for the output register
  state_t state;
  logic   done;

  logic [VAL_W-1:0] miss_value;
  logic [PCT_W-1:0] load_threshold_pct;

  logic [CW-1:0] live_count;
  logic [CW-1:0] first_used;
  logic [CW-1:0] past_last_used;

  logic [IW-1:0]    idx;
  logic [IW-1:0]    home;
  logic [IW-1:0]    probe_ofs;
  logic [IW-1:0]    grave;
  logic             grave_v;
  logic             want_free;
  logic             is_put;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [IW-1:0]    rslot;
  logic [JW-1:0]    scan;
  logic [IW-1:0]    clr;
  logic             clr_emit;

  logic [STAT_W-1:0] res_status;
  logic              res_existed;
  logic [SOUT_W-1:0] res_slot;
  logic [VAL_W-1:0]  res_value;

  store_wr_t        wr;
  logic [IW-1:0]    mem_addr;
  logic [VAL_W-1:0] wval;
  logic [1:0]       rflags;
  logic [KEY_W-1:0] rkey;
  logic [VAL_W-1:0] rval;

  logic             rd_live;
  logic             rd_occ;
  logic             rd_tomb;
  logic [IW-1:0]    probe_next;
  logic [JW-1:0]    scan_inc;
  logic [KEY_W-1:0] req_mix;
  logic             out_free;
  logic             rm_bad;

  assign req.ready  = (state == S_IDLE) && !done;
  assign out_free   = !rsp.valid || rsp.ready;
  assign rd_occ     = rflags[0];
  assign rd_tomb    = rflags[1];
  assign rd_live    = rd_occ && !rd_tomb;
  // triangular step: offset grows by one each probe, wraps modulo the table size
  assign probe_next = idx + probe_ofs + IW'(1);
  assign scan_inc   = scan + JW'(1);
  assign req_mix    = key_mix(req.key);
  assign mem_addr   = (state == S_CLEAR) ? clr : idx;
  // remove refused up front: empty table or slot past the table
  assign rm_bad     = (live_count == '0) || (JW'(req.slot) >= JW'(BUCKETS));

  always_comb begin
    wr   = '0;
    wval = is_put ? val_r : miss_value;
    case (state)
      S_CLEAR: begin
        wr.flag_we = 1'b1;
        wr.flags   = FL_EMPTY;
      end
      S_PRB_EVAL: begin
        // put on a live key overwrites the value in place
        if (rd_occ && !rd_tomb && rkey == key_r && is_put) wr.val_we = 1'b1;
      end
      S_INS_WR: begin
        wr.flag_we = 1'b1;
        wr.key_we  = 1'b1;
        wr.val_we  = 1'b1;
        wr.flags   = FL_LIVE;
      end
      S_REM_EVAL: begin
        if (rd_live) begin
          wr.flag_we = 1'b1;
          wr.flags   = FL_TOMB;
        end
      end
      default: ;
    endcase
  end

  oaht_store #(.DEPTH(BUCKETS), .IW(IW)) u_store (
    .clk    (clk),
    .addr   (mem_addr),
    .wr     (wr),
    .wkey   (key_r),
    .wval   (wval),
    .rflags (rflags),
    .rkey   (rkey),
    .rval   (rval)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_value         <= '0;
      load_threshold_pct <= PCT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT) miss_value <= cfg_data;
      if (cfg_index == CFG_THRESH)  load_threshold_pct <= cfg_data[PCT_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      done           <= 1'b0;
      clr            <= '0;
      clr_emit       <= 1'b0;
      live_count     <= '0;
      first_used     <= '0;
      past_last_used <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !(done && out_free)) rsp.valid <= 1'b0;

      if (done) begin
        // hold the result until the output register frees
        if (out_free) begin
          rsp.valid          <= 1'b1;
          rsp.status         <= res_status;
          rsp.existed        <= res_existed;
          rsp.slot_out       <= res_slot;
          rsp.value_out      <= res_value;
          rsp.entry_count    <= SOUT_W'(live_count);
          rsp.over_threshold <= (PW'(live_count) * PW'(PCT_SCALE)) >=
                                (PW'(BUCKETS) * PW'(load_threshold_pct));
          done               <= 1'b0;
          state              <= S_IDLE;
        end
      end else begin
        case (state)
          S_CLEAR: begin
            clr <= clr + IW'(1);
            if (clr == IW'(BUCKETS - 1)) begin
              state    <= S_IDLE;
              done     <= clr_emit;
              clr_emit <= 1'b0;
            end
          end

          S_IDLE: begin
            if (req.valid) begin
              key_r       <= req.key;
              val_r       <= req.value;
              is_put      <= (req.action == ACT_PUT);
              want_free   <= (req.action == ACT_INSERT) || (req.action == ACT_PUT);
              res_existed <= 1'b0;
              res_status  <= (req.action == ACT_REMOVE && rm_bad) ? ST_BAD_SLOT : ST_OK;
              res_slot    <= NO_SLOT;
              res_value   <= miss_value;
              case (req.action)
                ACT_LOOKUP, ACT_INSERT, ACT_PUT: begin
                  home      <= req_mix[IW-1:0];
                  idx       <= req_mix[IW-1:0];
                  probe_ofs <= '0;
                  grave_v   <= 1'b0;
                  state     <= S_PRB_ADDR;
                end
                ACT_REMOVE: begin
                  if (rm_bad) begin
                    done <= 1'b1;
                  end else begin
                    idx   <= IW'(req.slot);
                    rslot <= IW'(req.slot);
                    state <= S_REM_ADDR;
                  end
                end
                ACT_NEXT: begin
                  scan  <= JW'(req.slot) + JW'(1);
                  idx   <= IW'(JW'(req.slot) + JW'(1));
                  state <= S_NXT_ADDR;
                end
                ACT_RESET: begin
                  live_count     <= '0;
                  first_used     <= '0;
                  past_last_used <= '0;
                  clr            <= '0;
                  clr_emit       <= 1'b1;
                  state          <= S_CLEAR;
                end
                default: done <= 1'b1;
              endcase
            end
          end

          S_PRB_ADDR: state <= S_PRB_EVAL;

          S_PRB_EVAL: begin
            if (!rd_occ) begin
              // never-used slot ends the probe
              if (want_free) begin
                state <= S_INS_WR;
              end else begin
                res_status <= ST_NOT_FOUND;
                done       <= 1'b1;
              end
            end else if (!rd_tomb && rkey == key_r) begin
              res_slot <= SOUT_W'(idx);
              if (want_free) res_existed <= 1'b1;
              res_value <= is_put ? val_r : rval;
              done      <= 1'b1;
            end else begin
              if (rd_tomb && want_free && !grave_v) begin
                grave   <= idx;
                grave_v <= 1'b1;
              end
              probe_ofs <= probe_ofs + IW'(1);
              if (probe_next == home) begin
                // wrapped: reuse the first tombstone passed, if any
                if (want_free && (grave_v || rd_tomb)) begin
                  idx   <= grave_v ? grave : idx;
                  state <= S_INS_WR;
                end else begin
                  res_status <= want_free ? ST_FULL : ST_NOT_FOUND;
                  done       <= 1'b1;
                end
              end else begin
                idx   <= probe_next;
                state <= S_PRB_ADDR;
              end
            end
          end

          S_INS_WR: begin
            live_count <= live_count + CW'(1);
            if (first_used == past_last_used || CW'(idx) < first_used) first_used <= CW'(idx);
            if (CW'(idx) + CW'(1) > past_last_used) past_last_used <= CW'(idx) + CW'(1);
            res_slot  <= SOUT_W'(idx);
            res_value <= wval;
            done      <= 1'b1;
          end

          S_REM_ADDR: state <= S_REM_EVAL;

          S_REM_EVAL: begin
            if (!rd_live) begin
              res_status <= ST_BAD_SLOT;
              done       <= 1'b1;
            end else begin
              live_count <= live_count - CW'(1);
              res_slot   <= SOUT_W'(rslot);
              res_value  <= rval;
              if (first_used == CW'(rslot)) begin
                scan  <= JW'(rslot);
                state <= S_UP_ADDR;
              end else if (JW'(past_last_used) == JW'(rslot) + JW'(1)) begin
                scan  <= JW'(rslot);
                state <= S_DN_ADDR;
              end else begin
                done <= 1'b1;
              end
            end
          end

          S_UP_ADDR: begin
            if (scan < JW'(past_last_used)) begin
              state <= S_UP_EVAL;
            end else begin
              first_used <= '0;
              if (JW'(past_last_used) == JW'(rslot) + JW'(1)) begin
                scan  <= JW'(rslot);
                idx   <= rslot;
                state <= S_DN_ADDR;
              end else begin
                done <= 1'b1;
              end
            end
          end

          S_UP_EVAL: begin
            if (rd_live) begin
              first_used <= CW'(scan);
              if (JW'(past_last_used) == JW'(rslot) + JW'(1)) begin
                scan  <= JW'(rslot);
                idx   <= rslot;
                state <= S_DN_ADDR;
              end else begin
                done <= 1'b1;
              end
            end else begin
              scan  <= scan_inc;
              idx   <= IW'(scan_inc);
              state <= S_UP_ADDR;
            end
          end

          S_DN_ADDR: state <= S_DN_EVAL;

          S_DN_EVAL: begin
            if (rd_live) begin
              past_last_used <= CW'(scan) + CW'(1);
              done           <= 1'b1;
            end else if (scan == '0) begin
              past_last_used <= '0;
              done           <= 1'b1;
            end else begin
              scan  <= scan - JW'(1);
              idx   <= IW'(scan - JW'(1));
              state <= S_DN_ADDR;
            end
          end

          S_NXT_ADDR: begin
            if (scan < JW'(past_last_used)) begin
              state <= S_NXT_EVAL;
            end else begin
              res_status <= ST_ITER_END;
              res_slot   <= SOUT_W'(past_last_used);
              done       <= 1'b1;
            end
          end

          S_NXT_EVAL: begin
            if (rd_live) begin
              res_slot  <= SOUT_W'(scan);
              res_value <= rval;
              done      <= 1'b1;
            end else begin
              scan  <= scan_inc;
              idx   <= IW'(scan_inc);
              state <= S_NXT_ADDR;
            end
          end

          default: state <= S_IDLE;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    JW'(live_count) <= JW'(BUCKETS))
    else $error("live count above table size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second beat taken while busy");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (live_count != '0 && state == S_IDLE) |-> (first_used < past_last_used))
    else $error("occupied bounds out of order");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("beat accepted during clearing pass");
`endif

endmodule
